### src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define FEPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fepp assertion failed");

// expression must never be true outside reset
`define FEPP_NEVER(lbl, clk, rst, expr) \
   `FEPP_ASSERT(lbl, clk, rst, !(expr))

`endif

### src/fepp_pkg.sv
package fepp_pkg;

   localparam int DEPTH      = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int DATA_W     = 32;
   localparam int POS_W      = 6;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // one beat handed from the front to the back, last already resolved
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } item_type;

endpackage

### src/fepp_front.sv
module fepp_front
   import fepp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   output logic                     q_push,
   output item_type                 q_item,
   input  logic                     q_full
);

   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             blk_end;

   assign req_full = valid_ff & q_full;
   assign accept   = req_push & ~req_full;
   // a block ends on the marked beat or when the store would be full
   assign blk_end  = req_is_last | (cnt_ff == IDX_W'(DEPTH - 1));

   always_comb begin
      valid_in = accept | (valid_ff & q_full);
      item_in  = item_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         item_in.value = req_value;
         item_in.last  = blk_end;
         cnt_in        = blk_end ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      item_ff <= item_in;
   end

   assign q_push = valid_ff & ~q_full;
   assign q_item = item_ff;

endmodule

### src/fepp_fifo.sv
module fepp_fifo
   import fepp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];

endmodule

### src/fepp_core.sv
`include "assert_macros.svh"

module fepp_core
   import fepp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   output logic                     q_pop,
   input  item_type                 q_item,
   input  logic                     q_empty,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [POS_W-1:0]         rsp_position,
   output logic [POS_W-1:0]         rsp_pivot_index,
   output logic                     rsp_end_of_block
);

   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_SCAN_RD = 4'd1;
   localparam logic [3:0] S_CMP     = 4'd2;
   localparam logic [3:0] S_SWAP_A  = 4'd3;
   localparam logic [3:0] S_SWAP_B  = 4'd4;
   localparam logic [3:0] S_FIX_A   = 4'd5;
   localparam logic [3:0] S_FIX_B   = 4'd6;
   localparam logic [3:0] S_EMIT_RD = 4'd7;
   localparam logic [3:0] S_EMIT_WR = 4'd8;

   logic [DATA_W-1:0] store [DEPTH];

   logic [3:0]               state_ff, state_in;
   logic [IDX_W-1:0]         load_ff, load_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic signed [DATA_W-1:0] pv_ff, pv_in;
   logic [DATA_W-1:0]        a_ff, a_in;
   logic [DATA_W-1:0]        rd_ff;

   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_elem_ff, out_elem_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic [POS_W-1:0]         out_piv_ff, out_piv_in;
   logic                     out_end_ff, out_end_in;

   logic              we, re;
   logic [IDX_W-1:0]  wa, ra;
   logic [DATA_W-1:0] wd;
   logic [CNT_W-1:0]  piv_at;
   logic              out_free;

   assign piv_at   = left_ff - CNT_W'(1);
   assign out_free = ~out_valid_ff | rsp_pop;
   assign q_pop    = (state_ff == S_LOAD) & ~q_empty;

   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      n_in         = n_ff;
      scan_in      = scan_ff;
      left_in      = left_ff;
      k_in         = k_ff;
      pv_in        = pv_ff;
      a_in         = a_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_elem_in  = out_elem_ff;
      out_pos_in   = out_pos_ff;
      out_piv_in   = out_piv_ff;
      out_end_in   = out_end_ff;
      we           = 1'b0;
      re           = 1'b0;
      wa           = '0;
      ra           = '0;
      wd           = '0;
      case (state_ff)
         S_LOAD: begin
            if (!q_empty) begin
               we = 1'b1;
               wa = load_ff;
               wd = q_item.value;
               if (load_ff == '0) begin
                  pv_in = q_item.value;
               end
               if (q_item.last) begin
                  n_in     = CNT_W'(load_ff) + CNT_W'(1);
                  load_in  = '0;
                  state_in = S_SCAN_RD;
               end else begin
                  load_in = load_ff + IDX_W'(1);
               end
            end
         end
         S_SCAN_RD: begin
            re = 1'b1;
            if (scan_ff == n_ff) begin
               // scan done, fetch the slot that takes the pivot
               ra       = piv_at[IDX_W-1:0];
               state_in = S_FIX_A;
            end else begin
               ra       = scan_ff[IDX_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if ($signed(rd_ff) < pv_ff) begin
               a_in     = rd_ff;
               re       = 1'b1;
               ra       = left_ff[IDX_W-1:0];
               state_in = S_SWAP_A;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_SWAP_A: begin
            we       = 1'b1;
            wa       = scan_ff[IDX_W-1:0];
            wd       = rd_ff;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            we       = 1'b1;
            wa       = left_ff[IDX_W-1:0];
            wd       = a_ff;
            left_in  = left_ff + CNT_W'(1);
            scan_in  = scan_ff + CNT_W'(1);
            state_in = S_SCAN_RD;
         end
         S_FIX_A: begin
            we       = 1'b1;
            wa       = '0;
            wd       = rd_ff;
            state_in = S_FIX_B;
         end
         S_FIX_B: begin
            we       = 1'b1;
            wa       = piv_at[IDX_W-1:0];
            wd       = pv_ff;
            k_in     = '0;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            re       = 1'b1;
            ra       = k_ff;
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_elem_in  = rd_ff;
               out_pos_in   = POS_W'(k_ff);
               out_piv_in   = POS_W'(piv_at);
               out_end_in   = (CNT_W'(k_ff) + CNT_W'(1) == n_ff);
               if (CNT_W'(k_ff) + CNT_W'(1) == n_ff) begin
                  scan_in  = CNT_W'(1);
                  left_in  = CNT_W'(1);
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store[wa] <= wd;
      end
      if (re) begin
         rd_ff <= store[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_ff      <= '0;
         n_ff         <= CNT_W'(1);
         scan_ff      <= CNT_W'(1);
         left_ff      <= CNT_W'(1);
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         n_ff         <= n_in;
         scan_ff      <= scan_in;
         left_ff      <= left_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
      pv_ff       <= pv_in;
      a_ff        <= a_in;
      out_elem_ff <= out_elem_in;
      out_pos_ff  <= out_pos_in;
      out_piv_ff  <= out_piv_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_element      = out_elem_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_pivot_index  = out_piv_ff;
   assign rsp_end_of_block = out_end_ff;

   // left slot can never pass the scan pointer
   `FEPP_ASSERT(a_left_le_scan, clock, reset, (left_ff >= CNT_W'(1)) && (left_ff <= scan_ff))
   // scan stays inside the loaded block
   `FEPP_NEVER(a_scan_in_block, clock, reset, (state_ff != S_LOAD) && (scan_ff > n_ff))
   // block length is never zero nor above the store size
   `FEPP_ASSERT(a_n_range, clock, reset, (n_ff >= CNT_W'(1)) && (n_ff <= CNT_W'(DEPTH)))

endmodule

### src/first_element_pivot_partition_top.sv
// first-element pivot partition
// input queue: req_push / req_full with req_value (signed 32) and req_is_last.
// a block is the run of beats up to the one marked last, or 64 beats.
// result queue: rsp_empty / rsp_pop; while rsp_empty is low the oldest result
// sits on rsp_element, rsp_position, rsp_pivot_index and rsp_end_of_block.
// a finished block comes out as one result per element, in slot order, with
// the pivot's final slot on every beat and end_of_block on the last.
// input beats pass an input register and a 4-entry queue, then are written to
// a 64-word single-port-write store at one beat per cycle while the core is loading.
// partition scan over the one store: each element is read, then compared with
// the pivot; one moved left also has the left slot read and both slots written.
// the pivot is placed by reading its final slot, writing that value to slot 0
// and the pivot into its final slot.
// emit: per element a store read, then the output register is loaded.
// while a block is scanned or emitted, new beats fill the input queue and
// req_full rises once it and the input register are full.
// a stalled receiver holds the output register and pauses the emit sequence.
// reset clears all control state; the store needs no clearing since only
// slots of the current block are read.
module first_element_pivot_partition_top
   import fepp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [POS_W-1:0]         rsp_position,
   output logic [POS_W-1:0]         rsp_pivot_index,
   output logic                     rsp_end_of_block
);

   logic     f_push, f_full, f_pop, f_empty;
   item_type f_in_item, f_out_item;

   fepp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_value   (req_value),
      .req_is_last (req_is_last),
      .q_push      (f_push),
      .q_item      (f_in_item),
      .q_full      (f_full)
   );

   fepp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_in_item),
      .full      (f_full),
      .pop       (f_pop),
      .pop_item  (f_out_item),
      .empty     (f_empty)
   );

   fepp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .q_pop            (f_pop),
      .q_item           (f_out_item),
      .q_empty          (f_empty),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_element      (rsp_element),
      .rsp_position     (rsp_position),
      .rsp_pivot_index  (rsp_pivot_index),
      .rsp_end_of_block (rsp_end_of_block)
   );

endmodule

### bench/partition_checker.sv
`timescale 1ns / 1ps

// watches both queues, rebuilds each partitioned block and compares every result beat
module partition_checker
   import fepp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic signed [DATA_W-1:0] rsp_element,
   input  logic [POS_W-1:0]         rsp_position,
   input  logic [POS_W-1:0]         rsp_pivot_index,
   input  logic                     rsp_end_of_block,
   output int                       mismatch_count,
   output int                       awaited_count,
   output int                       beats_compared,
   output int                       blocks_partitioned
);

   typedef struct {
      logic signed [DATA_W-1:0] element;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         pivot_index;
      logic                     end_of_block;
   } slot_result_type;

   slot_result_type          partitioned_slots[$];
   logic signed [DATA_W-1:0] block_values[DEPTH];
   int                       fill;

   initial begin
      mismatch_count     = 0;
      awaited_count      = 0;
      beats_compared     = 0;
      blocks_partitioned = 0;
      fill               = 0;
   end

   always @(posedge clock) begin : watch
      logic signed [DATA_W-1:0] pivot;
      logic signed [DATA_W-1:0] held;
      slot_result_type          want;
      slot_result_type          got;
      int                       lo;
      int                       k;
      if (reset) begin
         fill = 0;
         partitioned_slots.delete();
      end else begin
         if (req_push && !req_full) begin
            block_values[fill] = req_value;
            fill++;
            // a full store closes the block whatever the last mark says
            if (req_is_last || fill == DEPTH) begin
               pivot = block_values[0];
               lo = 1;
               for (k = 1; k < fill; k++) begin
                  if (block_values[k] < pivot) begin
                     held             = block_values[k];
                     block_values[k]  = block_values[lo];
                     block_values[lo] = held;
                     lo++;
                  end
               end
               held                 = block_values[0];
               block_values[0]      = block_values[lo - 1];
               block_values[lo - 1] = held;
               for (k = 0; k < fill; k++) begin
                  want.element      = block_values[k];
                  want.position     = k[POS_W-1:0];
                  want.pivot_index  = POS_W'(lo - 1);
                  want.end_of_block = (k == fill - 1);
                  partitioned_slots.push_back(want);
               end
               fill = 0;
               blocks_partitioned++;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            got.element      = rsp_element;
            got.position     = rsp_position;
            got.pivot_index  = rsp_pivot_index;
            got.end_of_block = rsp_end_of_block;
            if (partitioned_slots.size() == 0) begin
               $error("result beat with nothing expected: element %0d position %0d",
                      got.element, got.position);
               mismatch_count++;
            end else begin
               want = partitioned_slots.pop_front();
               beats_compared++;
               if (got.element !== want.element) begin
                  $error("element mismatch: expected %0d, got %0d", want.element, got.element);
                  mismatch_count++;
               end
               if (got.position !== want.position) begin
                  $error("position mismatch: expected %0d, got %0d",
                         want.position, got.position);
                  mismatch_count++;
               end
               if (got.pivot_index !== want.pivot_index) begin
                  $error("pivot_index mismatch: expected %0d, got %0d",
                         want.pivot_index, got.pivot_index);
                  mismatch_count++;
               end
               if (got.end_of_block !== want.end_of_block) begin
                  $error("end_of_block mismatch: expected %0d, got %0d",
                         want.end_of_block, got.end_of_block);
                  mismatch_count++;
               end
            end
         end
      end
      awaited_count = partitioned_slots.size();
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import fepp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BEATS = 240;

   localparam int MODE_FULL    = 0;
   localparam int MODE_NARROW  = 1;
   localparam int MODE_EXTREME = 2;

   logic                     clock;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic signed [DATA_W-1:0] req_value;
   logic                     req_is_last;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic signed [DATA_W-1:0] rsp_element;
   logic [POS_W-1:0]         rsp_position;
   logic [POS_W-1:0]         rsp_pivot_index;
   logic                     rsp_end_of_block;

   int mismatch_count;
   int awaited_count;
   int beats_compared;
   int blocks_partitioned;
   int beats_sent;
   int cycle_count;
   bit steady_flow;

   first_element_pivot_partition_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_element      (rsp_element),
      .rsp_position     (rsp_position),
      .rsp_pivot_index  (rsp_pivot_index),
      .rsp_end_of_block (rsp_end_of_block)
   );

   partition_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_value          (req_value),
      .req_is_last        (req_is_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_element        (rsp_element),
      .rsp_position       (rsp_position),
      .rsp_pivot_index    (rsp_pivot_index),
      .rsp_end_of_block   (rsp_end_of_block),
      .mismatch_count     (mismatch_count),
      .awaited_count      (awaited_count),
      .beats_compared     (beats_compared),
      .blocks_partitioned (blocks_partitioned)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, awaited_count);
         $display("first_element_pivot_partition_top verification failed");
         $finish;
      end
   end

   // receiver side
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop = steady_flow || ($urandom_range(0, 99) >= 7);
      end
   end

   task automatic push_beat(input logic signed [DATA_W-1:0] value, input logic last);
      while (!steady_flow && $urandom_range(0, 99) < 7) begin
         @(negedge clock);
         req_push    = 1'b0;
         req_value   = $urandom;
         req_is_last = 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      @(negedge clock);
      req_push    = 1'b1;
      req_value   = value;
      req_is_last = last;
      do @(posedge clock); while (req_full);
      beats_sent++;
   endtask

   // sender holds off until the block has drained every result
   task automatic drain_results();
      @(negedge clock);
      req_push = 1'b0;
      while (awaited_count != 0) @(posedge clock);
   endtask

   // full range, narrow range with many equal keys, or extremes mixed in
   task automatic send_block(input int count, input int mode, input bit mark_end);
      logic signed [DATA_W-1:0] value;
      for (int i = 0; i < count; i++) begin
         case (mode)
            MODE_NARROW: value = $signed($urandom_range(0, 8)) - 4;
            MODE_EXTREME: begin
               case ($urandom_range(0, 4))
                  0: value = 32'sh8000_0000;
                  1: value = 32'sh7fff_ffff;
                  2: value = '0;
                  3: value = -1;
                  default: value = $urandom;
               endcase
            end
            default: value = $urandom;
         endcase
         push_beat(value, (i == count - 1) && (mark_end || count < DEPTH));
      end
   endtask

   initial begin
      int random_start;
      int block_no;
      int size_pick;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_value   = '0;
      req_is_last = 1'b0;
      steady_flow = 1'b0;
      beats_sent  = 0;
      cycle_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-element blocks at both extremes
      push_beat(32'sh8000_0000, 1'b1);
      push_beat(32'sh7fff_ffff, 1'b1);
      // two elements, second smaller
      push_beat(32'sh7fff_ffff, 1'b0);
      push_beat(32'sh8000_0000, 1'b1);
      // equal keys stay right of the moved ones
      push_beat(5, 1'b0);
      push_beat(5, 1'b0);
      push_beat(3, 1'b0);
      push_beat(5, 1'b0);
      push_beat(7, 1'b0);
      push_beat(3, 1'b1);
      // pivot is the minimum, nothing moves
      push_beat(32'sh8000_0000, 1'b0);
      push_beat(0, 1'b0);
      push_beat(32'sh8000_0000, 1'b0);
      push_beat(-1, 1'b1);
      // pivot is the maximum, all but its equal move left
      push_beat(32'sh7fff_ffff, 1'b0);
      push_beat(32'sh8000_0000, 1'b0);
      push_beat(32'sh7fff_ffff, 1'b0);
      push_beat(0, 1'b0);
      push_beat(1, 1'b1);
      drain_results();

      random_start = beats_sent;
      // store fills with no last mark on the final beat
      send_block(DEPTH, MODE_FULL, 1'b0);
      block_no = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         steady_flow = (block_no >= 20 && block_no < 32);
         if (block_no == 12) begin
            send_block(DEPTH, MODE_NARROW, 1'b1);
         end else begin
            size_pick = $urandom_range(0, 99);
            if (size_pick < 60)
               send_block($urandom_range(1, 6), $urandom_range(MODE_FULL, MODE_EXTREME), 1'b1);
            else if (size_pick < 90)
               send_block($urandom_range(7, 16), $urandom_range(MODE_FULL, MODE_EXTREME), 1'b1);
            else
               send_block($urandom_range(17, 40), $urandom_range(MODE_FULL, MODE_EXTREME), 1'b1);
         end
         if (block_no % 15 == 7)
            drain_results();
         block_no++;
      end
      steady_flow = 1'b0;

      drain_results();
      repeat (40) @(posedge clock);

      $display("sent %0d beats in %0d blocks: single, equal-key, extreme and 64-deep blocks",
               beats_sent, blocks_partitioned);
      $display("compared %0d result beats, %0d mismatches", beats_compared, mismatch_count);
      if (mismatch_count == 0)
         $display("first_element_pivot_partition_top verification clean");
      else
         $display("first_element_pivot_partition_top verification failed");
      $finish;
   end

endmodule

### first_element_pivot_partition_top.f
+incdir+src
src/fepp_pkg.sv
src/fepp_front.sv
src/fepp_fifo.sv
src/fepp_core.sv
src/first_element_pivot_partition_top.sv
bench/partition_checker.sv
bench/testbench.sv
